### sv/display_frame_settings_parser_defines.svh
// assertion macros shared by the settings parser modules
`ifndef DISPLAY_FRAME_SETTINGS_PARSER_DEFINES_SVH
`define DISPLAY_FRAME_SETTINGS_PARSER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DFSP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dfsp check failed");

// next-cycle implication, disabled during reset
`define DFSP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dfsp check failed");

`endif

### sv/dfsp_pkg.sv
// types, constants and widget packing for the display frame settings parser
package dfsp_pkg;

   localparam logic [7:0] HDR0     = 8'h5A;
   localparam logic [7:0] HDR1     = 8'hA5;
   localparam logic [7:0] CMD_READ = 8'h83;
   localparam logic [8:0] MIN_VALUE_LEN = 9'd9;

   localparam logic [15:0] ADDR_TEMP_UNIT = 16'h5110;
   localparam logic [15:0] ADDR_TEMP_EN   = 16'h5111;
   localparam logic [15:0] ADDR_PRESS_UNIT = 16'h5120;
   localparam logic [15:0] ADDR_PRESS_EN  = 16'h5121;
   localparam logic [15:0] ADDR_HUM_EN    = 16'h5131;
   localparam logic [15:0] ADDR_AQI_EN    = 16'h5141;

   localparam logic [2:0] PARAM_NONE  = 3'd0;
   localparam logic [2:0] PARAM_PRESS = 3'd1;
   localparam logic [2:0] PARAM_TEMP  = 3'd2;
   localparam logic [2:0] PARAM_HUMID = 3'd3;
   localparam logic [2:0] PARAM_AIR   = 3'd4;

   localparam logic [2:0] UNIT_F        = 3'd0;
   localparam logic [2:0] UNIT_C        = 3'd1;
   localparam logic [2:0] UNIT_MM_WATER = 3'd2;
   localparam logic [2:0] UNIT_RH       = 3'd3;
   localparam logic [2:0] UNIT_PA       = 3'd4;
   localparam logic [2:0] UNIT_NONE     = 3'd5;

   localparam logic [1:0] LAST_SLOT = 2'd3;

   typedef struct packed {
      logic temp_unit;
      logic press_unit;
      logic temp_en;
      logic press_en;
      logic hum_en;
      logic aqi_en;
   } settings_type;

   typedef struct packed {
      logic [2:0] unit;
      logic [2:0] param;
   } widget_type;

   typedef widget_type [3:0] widget_set_type;

   // enabled parameters packed from slot 0 upward, blanks after them
   function automatic widget_set_type pack_widgets(input settings_type s);
      widget_set_type set;
      widget_type     cand [4];
      logic [3:0]     en;
      logic [2:0]     n;
      set = '0;
      for (int i = 0; i < 4; i++) begin
         set[i].param = PARAM_NONE;
         set[i].unit  = UNIT_NONE;
      end
      cand[0].param = PARAM_TEMP;
      cand[0].unit  = s.temp_unit ? UNIT_C : UNIT_F;
      cand[1].param = PARAM_PRESS;
      cand[1].unit  = s.press_unit ? UNIT_PA : UNIT_MM_WATER;
      cand[2].param = PARAM_HUMID;
      cand[2].unit  = UNIT_RH;
      cand[3].param = PARAM_AIR;
      cand[3].unit  = UNIT_NONE;
      en = {s.aqi_en, s.hum_en, s.press_en, s.temp_en};
      n  = 3'd0;
      for (int i = 0; i < 4; i++) begin
         if (en[i]) begin
            set[n[1:0]] = cand[i];
            n = n + 3'd1;
         end
      end
      return set;
   endfunction

endpackage

### sv/display_frame_settings_parser.sv
// top level of the display frame settings parser
//
// Takes received link bytes on the req_ stream, one byte per item, and hunts
// for settings frames (header, length, command, address, word count, value).
// A read-command frame of nine bytes or more aimed at one of the six setting
// addresses updates a unit or enable flag and then sends a run of four widget
// assignments on the rsp_ stream, slots 0 to 3, with tlast on the fourth.
// A byte accepted into the input register is parsed from there; the byte that
// ends an updating frame loads the result register, which offers the first widget.
// Throughput: one byte per cycle when not stalled as below; the input and result
// registers work in parallel, so bytes keep flowing while a run is played out.
// A run holds the result register for four accepted items; a second run that
// completes before the first has drained stalls req_tready until it is free.
// When the receiver holds rsp_tready low the current widget stays put and
// the input stalls only once a byte that ends an updating frame is waiting.
// Reset (synchronous, active high) drops any partial frame, returns to the
// header hunt and clears all unit and enable flags.

module display_frame_settings_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,  // [7:0] rx_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,  // [1:0] widget_index, [4:2] parameter_code, [7:5] unit_code
   output logic       rsp_tlast   // last_widget
);

   logic                   load_valid;
   logic                   load_ready;
   dfsp_pkg::settings_type load_settings;

   dfsp_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .load_valid    (load_valid),
      .load_ready    (load_ready),
      .load_settings (load_settings)
   );

   dfsp_widget_out u_widget_out (
      .clock         (clock),
      .reset         (reset),
      .load_valid    (load_valid),
      .load_ready    (load_ready),
      .load_settings (load_settings),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast)
   );

endmodule

### sv/dfsp_parser.sv
// input register and frame parser that updates the display settings
`include "display_frame_settings_parser_defines.svh"

module dfsp_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   output logic                  load_valid,
   input  logic                  load_ready,
   output dfsp_pkg::settings_type load_settings
);

   localparam logic [8:0] POS_HDR0  = 9'd0;
   localparam logic [8:0] POS_HDR1  = 9'd1;
   localparam logic [8:0] POS_LEN   = 9'd2;
   localparam logic [8:0] POS_CMD   = 9'd3;
   localparam logic [8:0] POS_ADDRH = 9'd4;
   localparam logic [8:0] POS_ADDRL = 9'd5;
   localparam logic [8:0] POS_WC    = 9'd6;
   localparam logic [8:0] POS_VALH  = 9'd7;
   localparam logic [8:0] POS_VALL  = 9'd8;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   logic [8:0]  pos_ff, pos_in;
   logic [8:0]  len_ff, len_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [15:0] addr_ff, addr_in;
   logic [7:0]  wc_ff, wc_in;
   logic [7:0]  valh_ff, valh_in;
   logic [7:0]  vall_ff, vall_in;
   dfsp_pkg::settings_type set_ff, set_in;

   logic       finish, frame_ok, addr_hit, zero, emit, advance;
   logic [8:0] frame_len;

   always_comb begin
      pos_in    = pos_ff;
      len_in    = len_ff;
      cmd_in    = cmd_ff;
      addr_in   = addr_ff;
      wc_in     = wc_ff;
      valh_in   = valh_ff;
      vall_in   = vall_ff;
      set_in    = set_ff;
      finish    = 1'b0;
      frame_len = len_ff;
      addr_hit  = 1'b1;
      if (pos_ff == POS_HDR0 && in_byte_ff != dfsp_pkg::HDR0) begin
         pos_in = pos_ff;
      end else if (pos_ff == POS_HDR1 && in_byte_ff != dfsp_pkg::HDR1) begin
         pos_in = POS_HDR0;
      end else begin
         unique case (pos_ff)
            POS_LEN:   len_in  = {1'b0, in_byte_ff} + 9'd3;
            POS_CMD:   cmd_in  = in_byte_ff;
            POS_ADDRH: addr_in = {in_byte_ff, addr_ff[7:0]};
            POS_ADDRL: addr_in = {addr_ff[15:8], in_byte_ff};
            POS_WC:    wc_in   = in_byte_ff;
            POS_VALH:  valh_in = in_byte_ff;
            POS_VALL:  vall_in = in_byte_ff;
            default:   ;
         endcase
         pos_in    = pos_ff + 9'd1;
         frame_len = len_in;
         if (len_in != 9'd0 && pos_in >= len_in) begin
            finish = 1'b1;
            pos_in = POS_HDR0;
            len_in = 9'd0;
         end
      end
      frame_ok = finish && frame_len >= dfsp_pkg::MIN_VALUE_LEN
                 && cmd_in == dfsp_pkg::CMD_READ && wc_in != 8'd0;
      zero = (valh_in == 8'd0) && (vall_in == 8'd0);
      if (frame_ok) begin
         unique case (addr_in)
            dfsp_pkg::ADDR_TEMP_UNIT:  set_in.temp_unit  = !zero;
            dfsp_pkg::ADDR_TEMP_EN:    set_in.temp_en    = zero;
            dfsp_pkg::ADDR_PRESS_UNIT: set_in.press_unit = !zero;
            dfsp_pkg::ADDR_PRESS_EN:   set_in.press_en   = zero;
            dfsp_pkg::ADDR_HUM_EN:     set_in.hum_en     = zero;
            dfsp_pkg::ADDR_AQI_EN:     set_in.aqi_en     = zero;
            default:                   addr_hit = 1'b0;
         endcase
      end
      emit = frame_ok && addr_hit;
   end

   assign load_valid    = in_valid_ff && emit;
   assign load_settings = set_in;
   // an item that starts a widget run waits for the output stage
   assign advance       = in_valid_ff && (!emit || load_ready);
   assign req_tready    = !in_valid_ff || advance;

   always_comb begin
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pos_ff      <= 9'd0;
         len_ff      <= 9'd0;
         set_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            pos_ff <= pos_in;
            len_ff <= len_in;
            set_ff <= set_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
      if (advance) begin
         cmd_ff  <= cmd_in;
         addr_ff <= addr_in;
         wc_ff   <= wc_in;
         valh_ff <= valh_in;
         vall_ff <= vall_in;
      end
   end

   `DFSP_ASSERT_NOW(a_hunt_no_len, clock, reset, pos_ff <= POS_LEN, len_ff == 9'd0)
   `DFSP_ASSERT_NOW(a_pos_below_len, clock, reset, len_ff != 9'd0, pos_ff < len_ff)

endmodule

### sv/dfsp_widget_out.sv
// result register that plays out one run of four widget assignments
`include "display_frame_settings_parser_defines.svh"

module dfsp_widget_out (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load_valid,
   output logic                  load_ready,
   input  dfsp_pkg::settings_type load_settings,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic                  rsp_tlast
);

   logic                     valid_ff, valid_in;
   logic [1:0]               slot_ff, slot_in;
   dfsp_pkg::widget_set_type widgets_ff;
   dfsp_pkg::widget_type     cur;
   logic                     take, load;

   assign take       = valid_ff && rsp_tready;
   assign load_ready = !valid_ff || (take && slot_ff == dfsp_pkg::LAST_SLOT);
   assign load       = load_valid && load_ready;

   always_comb begin
      valid_in = valid_ff;
      slot_in  = slot_ff;
      if (load) begin
         valid_in = 1'b1;
         slot_in  = 2'd0;
      end else if (take) begin
         if (slot_ff == dfsp_pkg::LAST_SLOT) begin
            valid_in = 1'b0;
         end
         slot_in = slot_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         slot_ff  <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         slot_ff  <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         widgets_ff <= dfsp_pkg::pack_widgets(load_settings);
      end
   end

   assign cur        = widgets_ff[slot_ff];
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {cur.unit, cur.param, slot_ff};
   assign rsp_tlast  = (slot_ff == dfsp_pkg::LAST_SLOT);

   `DFSP_ASSERT_NEXT(a_load_starts_run, clock, reset, load, valid_ff && slot_ff == 2'd0)
   `DFSP_ASSERT_NEXT(a_run_ends, clock, reset,
      take && slot_ff == dfsp_pkg::LAST_SLOT && !load_valid, !valid_ff)

endmodule

### test/tb_display_frame_settings_parser.sv
// self-checking testbench for the display frame settings parser
module tb_display_frame_settings_parser;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_BYTES = 480;

   localparam logic [15:0] SETTING_ADDRS [6] = '{dfsp_pkg::ADDR_TEMP_UNIT,
      dfsp_pkg::ADDR_TEMP_EN, dfsp_pkg::ADDR_PRESS_UNIT, dfsp_pkg::ADDR_PRESS_EN,
      dfsp_pkg::ADDR_HUM_EN, dfsp_pkg::ADDR_AQI_EN};
   // text field addresses, never acted on
   localparam logic [15:0] TEXT_ADDRS [3] = '{16'h5012, 16'h5022, 16'h5032};

   typedef struct packed {
      logic [1:0] slot;
      logic [2:0] param;
      logic [2:0] unit;
      logic       last;
   } tb_widget_type;

   typedef struct {
      logic [7:0] data;
      bit         hold;   // wait for every widget before sending this item
   } link_byte_type;

   logic       clock;
   logic       reset;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;  // [7:0] rx_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;  // [1:0] widget_index, [4:2] parameter_code, [7:5] unit_code
   logic       rsp_tlast;  // last_widget

   display_frame_settings_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   link_byte_type  link_bytes [$];
   tb_widget_type  widgets_due [$];
   link_byte_type  next_byte;
   tb_widget_type  got_widget;
   tb_widget_type  want_widget;
   bit          req_fire;
   int          req_gap;
   int          rsp_gap;
   int          bytes_sent;
   int          cycle_count;
   int          failures;
   int          updating_frames;
   int          widgets_checked;
   int          queued_bytes;

   // parser state as the block should hold it
   logic [8:0]   frame_pos;
   logic [8:0]   frame_len;
   logic [7:0]   frame_cmd;
   logic [15:0]  frame_addr;
   logic [7:0]   frame_words;
   logic [7:0]   value_hi;
   logic [7:0]   value_lo;
   dfsp_pkg::settings_type settings;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // one received byte: advance the frame parser, queue widgets on an update
   function automatic void parse_link_byte(input logic [7:0] b);
      logic [8:0] len;
      logic       zero;
      logic [2:0] prm [4];
      logic [2:0] unt [4];
      int         n;
      if (frame_pos == 9'd0 && b != dfsp_pkg::HDR0) return;
      if (frame_pos == 9'd1 && b != dfsp_pkg::HDR1) begin
         frame_pos = 9'd0;
         return;
      end
      case (frame_pos)
         9'd2: frame_len = {1'b0, b} + 9'd3;
         9'd3: frame_cmd = b;
         9'd4: frame_addr[15:8] = b;
         9'd5: frame_addr[7:0] = b;
         9'd6: frame_words = b;
         9'd7: value_hi = b;
         9'd8: value_lo = b;
         default: ;
      endcase
      frame_pos = frame_pos + 9'd1;
      if (frame_len == 9'd0 || frame_pos < frame_len) return;
      len       = frame_len;
      frame_pos = 9'd0;
      frame_len = 9'd0;
      if (len < dfsp_pkg::MIN_VALUE_LEN || frame_cmd != dfsp_pkg::CMD_READ ||
          frame_words == 8'd0) return;
      zero = (value_hi == 8'd0 && value_lo == 8'd0);
      case (frame_addr)
         dfsp_pkg::ADDR_TEMP_UNIT:  settings.temp_unit  = !zero;
         dfsp_pkg::ADDR_TEMP_EN:    settings.temp_en    = zero;
         dfsp_pkg::ADDR_PRESS_UNIT: settings.press_unit = !zero;
         dfsp_pkg::ADDR_PRESS_EN:   settings.press_en   = zero;
         dfsp_pkg::ADDR_HUM_EN:     settings.hum_en     = zero;
         dfsp_pkg::ADDR_AQI_EN:     settings.aqi_en     = zero;
         default: return;
      endcase
      updating_frames++;
      n = 0;
      if (settings.temp_en) begin
         prm[n] = dfsp_pkg::PARAM_TEMP;
         unt[n] = settings.temp_unit ? dfsp_pkg::UNIT_C : dfsp_pkg::UNIT_F;
         n++;
      end
      if (settings.press_en) begin
         prm[n] = dfsp_pkg::PARAM_PRESS;
         unt[n] = settings.press_unit ? dfsp_pkg::UNIT_PA : dfsp_pkg::UNIT_MM_WATER;
         n++;
      end
      if (settings.hum_en) begin
         prm[n] = dfsp_pkg::PARAM_HUMID;
         unt[n] = dfsp_pkg::UNIT_RH;
         n++;
      end
      if (settings.aqi_en) begin
         prm[n] = dfsp_pkg::PARAM_AIR;
         unt[n] = dfsp_pkg::UNIT_NONE;
         n++;
      end
      for (int k = 0; k < 4; k++) begin
         widgets_due.push_back('{slot: k[1:0],
                                 param: (k < n) ? prm[k] : dfsp_pkg::PARAM_NONE,
                                 unit: (k < n) ? unt[k] : dfsp_pkg::UNIT_NONE,
                                 last: (k[1:0] == dfsp_pkg::LAST_SLOT)});
      end
   endfunction

   function automatic int pick_gap(input bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic add_byte(input logic [7:0] b, input bit hold = 1'b0);
      link_bytes.push_back('{data: b, hold: hold});
      queued_bytes++;
   endtask

   // header, length byte, then as much of the body as the length allows
   task automatic add_frame(input logic [7:0] len_byte, input logic [7:0] cmd,
                            input logic [15:0] addr, input logic [7:0] words,
                            input logic [15:0] value, input bit hold = 1'b0);
      logic [7:0] body [6];
      body = '{cmd, addr[15:8], addr[7:0], words, value[15:8], value[7:0]};
      add_byte(dfsp_pkg::HDR0, hold);
      add_byte(dfsp_pkg::HDR1);
      add_byte(len_byte);
      for (int i = 0; i < len_byte; i++) begin
         add_byte((i < 6) ? body[i] : 8'($urandom));
      end
   endtask

   task automatic add_random_frame(input bit hold);
      int         r;
      logic [7:0] len_byte;
      logic [7:0] cmd;
      logic [15:0] addr;
      logic [7:0] words;
      logic [15:0] value;
      r = $urandom_range(0, 99);
      if (r < 70) len_byte = 8'd6;
      else if (r < 85) len_byte = 8'($urandom_range(7, 12));
      else if (r < 95) len_byte = 8'($urandom_range(0, 5));
      else len_byte = 8'($urandom_range(13, 40));
      cmd = ($urandom_range(0, 99) < 85) ? dfsp_pkg::CMD_READ : 8'($urandom);
      r = $urandom_range(0, 99);
      if (r < 80) addr = SETTING_ADDRS[$urandom_range(0, 5)];
      else if (r < 90) addr = TEXT_ADDRS[$urandom_range(0, 2)];
      else addr = 16'($urandom);
      r = $urandom_range(0, 99);
      if (r < 80) words = 8'd1;
      else if (r < 90) words = 8'd0;
      else words = 8'($urandom);
      r = $urandom_range(0, 99);
      if (r < 55) value = 16'h0000;
      else if (r < 65) value = ($urandom_range(0, 1) != 0) ? 16'h0001 : 16'h0100;
      else value = 16'($urandom);
      add_frame(len_byte, cmd, addr, words, value, hold);
   endtask

   // sender: one byte per item, random gaps, held while a drain is asked for
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (link_bytes.size() > 0 &&
                      (!link_bytes[0].hold || widgets_due.size() == 0)) begin
            next_byte = link_bytes.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_byte.data;
            req_gap = pick_gap(((bytes_sent / 60) % 4) == 0);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         rsp_gap = pick_gap(((cycle_count / 300) % 4) == 0);
      end
   end

   always @(posedge clock) begin
      req_fire = 1'b0;
      if (!reset) begin
         req_fire = req_tvalid && req_tready;
         if (req_fire) begin
            bytes_sent++;
            parse_link_byte(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            got_widget = {rsp_tdata[1:0], rsp_tdata[4:2], rsp_tdata[7:5], rsp_tlast};
            if (widgets_due.size() == 0) begin
               failures++;
               $display("%0t: unexpected widget slot %0d param %0d unit %0d last %0b",
                        $time, got_widget.slot, got_widget.param, got_widget.unit,
                        got_widget.last);
            end else begin
               want_widget = widgets_due.pop_front();
               widgets_checked++;
               if (got_widget.slot !== want_widget.slot ||
                   got_widget.param !== want_widget.param ||
                   got_widget.unit !== want_widget.unit ||
                   got_widget.last !== want_widget.last) begin
                  failures++;
                  $display("%0t: widget mismatch, expected %0d %0d %0d %0b, got %0d %0d %0d %0b",
                           $time, want_widget.slot, want_widget.param, want_widget.unit,
                           want_widget.last, got_widget.slot, got_widget.param,
                           got_widget.unit, got_widget.last);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run timed out with %0d bytes and %0d widgets outstanding",
                  $time, link_bytes.size(), widgets_due.size());
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      bit drain_asked;
      frame_pos = '0;
      frame_len = '0;
      frame_cmd = '0;
      frame_addr = '0;
      frame_words = '0;
      value_hi = '0;
      value_lo = '0;
      settings = '0;
      req_fire = 1'b0;
      req_gap = 0;
      rsp_gap = 0;
      bytes_sent = 0;
      cycle_count = 0;
      failures = 0;
      updating_frames = 0;
      widgets_checked = 0;
      queued_bytes = 0;
      drain_asked = 1'b0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // bytes skipped during the hunt
      add_byte(8'h00);
      add_byte(8'hFF);
      // repeated header byte: the second one is thrown away
      add_byte(dfsp_pkg::HDR0);
      add_byte(dfsp_pkg::HDR0);
      add_frame(8'd6, dfsp_pkg::CMD_READ, dfsp_pkg::ADDR_TEMP_EN, 8'd1, 16'h0000);
      // zero length byte
      add_frame(8'd0, dfsp_pkg::CMD_READ, dfsp_pkg::ADDR_TEMP_EN, 8'd1, 16'h0000);
      add_frame(8'd6, dfsp_pkg::CMD_READ, dfsp_pkg::ADDR_TEMP_UNIT, 8'hFF, 16'hFFFF);

      // mostly well formed frames, with noise and broken headers between them
      while (queued_bytes < RANDOM_BYTES) begin
         int r;
         r = $urandom_range(0, 99);
         if (r < 15) begin
            repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
         end else if (r < 20) begin
            add_byte(dfsp_pkg::HDR0);
            add_byte(8'($urandom));
         end
         if (!drain_asked && queued_bytes > RANDOM_BYTES / 2) begin
            // longest frame the length byte allows, sent once the block is idle
            add_frame(8'hFF, dfsp_pkg::CMD_READ, SETTING_ADDRS[$urandom_range(0, 5)], 8'd1,
                      16'h0000, 1'b1);
            drain_asked = 1'b1;
         end else begin
            add_random_frame(1'b0);
         end
      end

      while (link_bytes.size() > 0 || req_tvalid) @(posedge clock);
      while (widgets_due.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("sent %0d link bytes; %0d frames changed a setting, %0d widgets checked",
               bytes_sent, updating_frames, widgets_checked);
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", failures);
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### display_frame_settings_parser.f
+incdir+sv
sv/dfsp_pkg.sv
sv/dfsp_parser.sv
sv/dfsp_widget_out.sv
sv/display_frame_settings_parser.sv
test/tb_display_frame_settings_parser.sv
